// ----- rtl/psml_pkg.sv -----
// Shared types and constants of the port-security MAC limiter.
`default_nettype none
package psml_pkg;

   localparam int MAC_W = 48;
   localparam int VLAN_W = 12;
   localparam int CNT_W = 32;
   localparam int MAXA_W = 7;
   localparam int MODE_W = 2;
   localparam int LCNT_W = 5;
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REQ_CHECK = 2'd0;
   localparam logic [1:0] REQ_STICKY = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_RECOVER = 2'd3;

   localparam logic [MODE_W-1:0] MODE_SHUTDOWN = 2'd2;

   localparam logic [1:0] REG_MAX_ADDR = 2'd0;
   localparam logic [1:0] REG_MODE = 2'd1;
   localparam logic [1:0] REG_ENABLE = 2'd2;

   typedef struct packed {
      logic sticky;
      logic [VLAN_W-1:0] vlan_id;
      logic [MAC_W-1:0] mac_address;
   } entry_type;

   typedef struct packed {
      logic [MAXA_W-1:0] max_addresses;
      logic [MODE_W-1:0] violation_mode;
      logic port_enabled;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic scan_en;
      logic apply;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/psml_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psml_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/psml_ctrl.sv -----
// Request sequencer: accept, table scan, update and result hand-off.
`default_nettype none
module psml_ctrl
   import psml_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire stat_type stat,
   output cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/psml_datapath.sv -----
// Address table, scan counters, violation counters and result register.
`default_nettype none
module psml_datapath
   import psml_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire cmd_type cmd,
   output stat_type stat,
   input wire cfg_type cfg,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic [REQ_USER_W-1:0] req_tuser,
   input wire logic rsp_tready,
   output logic rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

   logic [1:0] req_type_ff;
   logic [MAC_W-1:0] mac_ff;
   logic [VLAN_W-1:0] vlan_ff;

   logic [CW-1:0] entry_count_ff, entry_count_in;
   logic err_dis_ff, err_dis_in;
   logic [CNT_W-1:0] pviol_ff, pviol_in;
   logic [CNT_W-1:0] tviol_ff, tviol_in;

   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic found_ff, found_in;
   logic [IW-1:0] found_idx_ff, found_idx_in;
   logic [CW-1:0] wr_ptr_ff, wr_ptr_in;

   logic status_ff, status_in;
   logic viol_ff, viol_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic issue;
   logic match;
   logic rd_en;
   logic wr_en;
   logic [IW-1:0] wr_addr;
   entry_type wr_data;
   entry_type rd_data;
   logic [CW+MAXA_W-1:0] count_wide;
   logic [CW+LCNT_W-1:0] count_out;
   logic below_limit;
   logic refused;

   psml_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(scan_idx_ff[IW-1:0]),
      .rd_data(rd_data)
   );

   assign issue = cmd.scan_en && (scan_idx_ff < entry_count_ff);
   assign rd_en = issue;
   assign match = (rd_data.mac_address == mac_ff) && (rd_data.vlan_id == vlan_ff);
   assign count_wide = {{MAXA_W{1'b0}}, entry_count_ff};
   assign count_out = {{LCNT_W{1'b0}}, entry_count_ff};
   assign below_limit = (count_wide[MAXA_W-1:0] < cfg.max_addresses)
                        && (entry_count_ff < CNT_CAP);
   assign refused = !cfg.port_enabled || err_dis_ff;

   assign stat = '{scan_done: !cmp_valid_ff && !(scan_idx_ff < entry_count_ff),
                   rsp_free: !rsp_valid_ff || rsp_tready};

   always_comb begin
      scan_idx_in = scan_idx_ff;
      cmp_valid_in = issue;
      cmp_idx_in = scan_idx_ff[IW-1:0];
      found_in = found_ff;
      found_idx_in = found_idx_ff;
      wr_ptr_in = wr_ptr_ff;
      entry_count_in = entry_count_ff;
      err_dis_in = err_dis_ff;
      pviol_in = pviol_ff;
      tviol_in = tviol_ff;
      status_in = status_ff;
      viol_in = viol_ff;
      wr_en = 1'b0;
      wr_addr = wr_ptr_ff[IW-1:0];
      wr_data = rd_data;

      if (cmd.start) begin
         scan_idx_in = '0;
         found_in = 1'b0;
         wr_ptr_in = '0;
      end
      if (issue) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
      if (cmp_valid_ff) begin
         if (match && !found_ff) begin
            found_in = 1'b1;
            found_idx_in = cmp_idx_ff;
         end
         if ((req_type_ff == REQ_CLEAR) && rd_data.sticky) begin
            wr_en = 1'b1;
            wr_addr = wr_ptr_ff[IW-1:0];
            wr_data = rd_data;
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end

      if (cmd.apply) begin
         status_in = 1'b0;
         viol_in = 1'b0;
         case (req_type_ff)
            REQ_CHECK: begin
               if (refused) begin
                  status_in = 1'b1;
               end else if (!found_ff) begin
                  if (below_limit) begin
                     wr_en = 1'b1;
                     wr_addr = entry_count_ff[IW-1:0];
                     wr_data = '{sticky: 1'b0, vlan_id: vlan_ff, mac_address: mac_ff};
                     entry_count_in = entry_count_ff + 1'b1;
                  end else begin
                     status_in = 1'b1;
                     viol_in = 1'b1;
                     pviol_in = (pviol_ff == '1) ? pviol_ff : pviol_ff + 1'b1;
                     tviol_in = (tviol_ff == '1) ? tviol_ff : tviol_ff + 1'b1;
                     if (cfg.violation_mode == MODE_SHUTDOWN) begin
                        err_dis_in = 1'b1;
                     end
                  end
               end
            end
            REQ_STICKY: begin
               if (found_ff) begin
                  wr_en = 1'b1;
                  wr_addr = found_idx_ff;
                  wr_data = '{sticky: 1'b1, vlan_id: vlan_ff, mac_address: mac_ff};
               end else begin
                  status_in = 1'b1;
               end
            end
            REQ_CLEAR: begin
               entry_count_in = wr_ptr_ff;
            end
            REQ_RECOVER: begin
               err_dis_in = 1'b0;
               pviol_in = '0;
            end
            default: begin
               status_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {tviol_ff, pviol_ff, count_out[LCNT_W-1:0], err_dis_ff,
                        viol_ff, status_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         err_dis_ff <= 1'b0;
         pviol_ff <= '0;
         tviol_ff <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         err_dis_ff <= err_dis_in;
         pviol_ff <= pviol_in;
         tviol_ff <= tviol_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         req_type_ff <= req_tuser;
         mac_ff <= req_tdata[MAC_W-1:0];
         vlan_ff <= req_tdata[MAC_W+VLAN_W-1:MAC_W];
      end
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff <= found_in;
      found_idx_ff <= found_idx_in;
      wr_ptr_ff <= wr_ptr_in;
      status_ff <= status_in;
      viol_ff <= viol_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule
`default_nettype wire

// ----- rtl/port_security_mac_limiter.sv -----
// Top level of the port-security MAC limiter: register port and block wiring.
//
// One instance guards one switch port. Requests arrive on the req_ stream: tuser holds the
// request kind (check, make sticky, clear dynamic, recover) and tdata the MAC and VLAN.
// Every request yields exactly one item on the rsp_ stream with status, violation flag,
// error-disable state, learned count and both violation counters.
// Limits and mode are set over the csr_ register port; the user must do so only while no
// request is in flight, as the block itself does not enforce it. A request is taken only
// when the engine is idle. It then scans the learned table one entry per cycle through the
// RAM read port. The next request can be taken in the cycle after a result is loaded.
// Clear dynamic compacts the table during the same scan through the RAM write port.
// The result sits in an output register; the next request is accepted while it waits, and
// a stalled receiver holds the engine only when the following result is ready.
// Reset empties the table, clears error-disable and both counters and restores the
// register defaults; table contents need no clearing pass.
`default_nettype none
module port_security_mac_limiter
   import psml_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: mac_address[47:0], vlan_id[59:48], zero fill.
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: req_type[1:0].
   input wire logic [REQ_USER_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // Fields from bit 0: status, violation, port_shut, learned_count[7:3],
   // port_violations[39:8], all_violations[71:40].
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic csr_psel,
   input wire logic csr_penable,
   input wire logic csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   cmd_type cmd;
   stat_type stat;
   logic csr_write;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_MAX_ADDR: cfg_in.max_addresses = csr_pwdata[MAXA_W-1:0];
            REG_MODE: cfg_in.violation_mode = csr_pwdata[MODE_W-1:0];
            REG_ENABLE: cfg_in.port_enabled = csr_pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MAX_ADDR: csr_prdata = {{(CSR_DATA_W-MAXA_W){1'b0}}, cfg_ff.max_addresses};
         REG_MODE: csr_prdata = {{(CSR_DATA_W-MODE_W){1'b0}}, cfg_ff.violation_mode};
         REG_ENABLE: csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.port_enabled};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_addresses <= MAXA_W'(1);
         cfg_ff.violation_mode <= '0;
         cfg_ff.port_enabled <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   psml_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat(stat),
      .cmd(cmd)
   );

   psml_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .cfg(cfg_ff),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata(rsp_tdata)
   );

endmodule
`default_nettype wire

// ----- rtl/psml_checker.sv -----
// Port-level checks of the limiter's result stream, bound to the top level.
`default_nettype none
module psml_checker
   import psml_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   a_viol_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("violation reported without refusal");

   a_viol_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> (rsp_tdata[39:8] != 0) && (rsp_tdata[71:40] != 0))
      else $error("violation reported with a zero counter");

   a_port_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:8] <= rsp_tdata[71:40])
      else $error("port violations exceed total violations");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {27'd0, rsp_tdata[7:3]} <= CAPACITY)
      else $error("learned count above capacity");

endmodule

bind port_security_mac_limiter psml_checker #(.CAPACITY(CAPACITY)) u_checker (.*);
`default_nettype wire
